@@ sv/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, codes and defaults for the dilated/strided 1-D convolution.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Default store dimensions (top-level parameter defaults)
  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_TAPS         = 16;
  localparam int DEF_MAX_LENGTH       = 256;

  // Q4.12 data, fixed by the beat format
  localparam int DATA_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int ROUND_HALF = 2048;
  localparam int RESULT_W   = 32;

  // Operation codes
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd2;
  localparam logic [1:0] OP_QUERY       = 2'd3;

  // Status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DILATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH    = 3'd6;

  typedef struct packed {
    logic [1:0]               op;
    logic [3:0]               out_channel;
    logic [3:0]               in_channel;
    logic [3:0]               tap;
    logic [7:0]               time_index;
    logic signed [DATA_W-1:0] value;
  } dsc_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       status;
  } dsc_out_t;

  // Sequencer to MAC control
  typedef struct packed {
    logic clear;      // load accumulator with scaled bias
    logic valid;      // operand beat present on w/x
    logic use_prod;   // operand pair lies inside the sample window
  } dsc_mac_ctl_t;

endpackage

@@ sv/dilated_strided_conv1d.sv @@
// ----------------------------------------------------------------------------
// dilated_strided_conv1d
// Multi-channel 1-D convolution with stride, zero padding and dilation.
// ----------------------------------------------------------------------------
// Loads (weight, bias, sample) are accepted while the block is idle and give
// no result. A query walks every (input channel, tap) pair through one shared
// multiply-accumulate, one pair per cycle, and holds the input side until its
// result is written; a query that falls outside the output length or output
// channel count skips the walk and returns status 1 with result 0. The pair
// rate is set by the single read port of the weight and sample memories. A
// finished result sits in the output register while loads keep flowing; a
// following query waits for it to be taken before its own result is written.
// Configuration writes are always accepted and must only be made while no
// query is in flight.
// ----------------------------------------------------------------------------
module dilated_strided_conv1d import dsc_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
  parameter int MAX_TAPS         = DEF_MAX_TAPS,
  parameter int MAX_LENGTH       = DEF_MAX_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dsc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dsc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CI_W   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int K_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SI_W   = $clog2(MAX_LENGTH);
  localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_IN_CHANNELS * MAX_TAPS) + 4;
  localparam int IDX_W  = 13;
  localparam int NUM_W  = 12;

  localparam int KN_MAX   = (MAX_TAPS < 16) ? MAX_TAPS : 16;
  localparam int CIN_MAX  = (MAX_IN_CHANNELS < 16) ? MAX_IN_CHANNELS : 16;
  localparam int COUT_MAX = (MAX_OUT_CHANNELS < 16) ? MAX_OUT_CHANNELS : 16;
  localparam int LEN_MAX  = (MAX_LENGTH < 256) ? MAX_LENGTH : 256;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // configuration registers (raw, clamped at use)
  logic [3:0] stride_r;
  logic [7:0] padding_r;
  logic [4:0] dilation_r, kernel_size_r, cin_cfg_r, out_channels_r;
  logic [8:0] in_length_r;

  logic [2:0]             state_r, state_nxt;
  logic [3:0]             oc_r, oc_nxt;
  logic [7:0]             tm_r, tm_nxt;
  logic [CI_W-1:0]        ci_r, ci_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic signed [IDX_W-1:0] base_r, base_nxt, idx_r, idx_nxt;
  logic                   err_r, err_nxt;
  logic                   rd_v_r, rd_use_r;
  logic                   out_valid_r, out_valid_nxt;
  dsc_out_t               out_data_r, out_data_nxt;

  logic [3:0]              s_use;
  logic [4:0]              d_use, kn_use, cin_use, cout_use;
  logic [8:0]              len_use;
  logic [9:0]              dk;
  logic signed [NUM_W-1:0] num;
  logic [11:0]             tms;
  logic signed [IDX_W-1:0] base_calc;
  logic                    err_calc;
  logic                    k_last, ci_last, idx_ok, in_acc, out_free;

  dsc_mac_ctl_t             mac_ctl;
  logic signed [DATA_W-1:0] bias_q, weight_q, sample_q;
  logic                     mac_busy;
  logic signed [RESULT_W-1:0] mac_result;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r       <= 4'd1;
      padding_r      <= 8'd0;
      dilation_r     <= 5'd1;
      kernel_size_r  <= 5'd1;
      cin_cfg_r      <= 5'd1;
      out_channels_r <= 5'd1;
      in_length_r    <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STRIDE:       stride_r       <= cfg_data[3:0];
        REG_PADDING:      padding_r      <= cfg_data[7:0];
        REG_DILATION:     dilation_r     <= cfg_data[4:0];
        REG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[4:0];
        REG_IN_CHANNELS:  cin_cfg_r      <= cfg_data[4:0];
        REG_OUT_CHANNELS: out_channels_r <= cfg_data[4:0];
        REG_IN_LENGTH:    in_length_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    s_use    = (stride_r == 4'd0) ? 4'd1 : ((stride_r > 4'd8) ? 4'd8 : stride_r);
    d_use    = (dilation_r == 5'd0) ? 5'd1 :
               ((dilation_r > 5'd16) ? 5'd16 : dilation_r);
    kn_use   = (kernel_size_r == 5'd0) ? 5'd1 :
               ((32'(kernel_size_r) > KN_MAX) ? 5'(KN_MAX) : kernel_size_r);
    cin_use  = (cin_cfg_r == 5'd0) ? 5'd1 :
               ((32'(cin_cfg_r) > CIN_MAX) ? 5'(CIN_MAX) : cin_cfg_r);
    cout_use = (out_channels_r == 5'd0) ? 5'd1 :
               ((32'(out_channels_r) > COUT_MAX) ? 5'(COUT_MAX) : out_channels_r);
    len_use  = (in_length_r == 9'd0) ? 9'd1 :
               ((32'(in_length_r) > LEN_MAX) ? 9'(LEN_MAX) : in_length_r);
  end

  // range check: t valid when t*stride <= num, channel valid when below the channel count
  always_comb begin
    dk        = 10'(d_use) * 10'(kn_use - 5'd1);
    num       = $signed({3'b000, len_use}) + $signed({3'b000, padding_r, 1'b0})
              - $signed({2'b00, dk}) - NUM_W'(1);
    tms       = 12'(tm_r) * 12'(s_use);
    base_calc = $signed({1'b0, tms}) - $signed({5'b00000, padding_r});
    err_calc  = num[NUM_W-1] ||
                ($signed({1'b0, tms}) > $signed({num[NUM_W-1], num})) ||
                ({1'b0, oc_r} >= cout_use);
  end

  always_comb begin
    k_last  = (5'(k_r) == (kn_use - 5'd1));
    ci_last = (5'(ci_r) == (cin_use - 5'd1));
    idx_ok  = !idx_r[IDX_W-1] && (idx_r < $signed({4'b0000, len_use}));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    oc_nxt        = oc_r;
    tm_nxt        = tm_r;
    ci_nxt        = ci_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.op == OP_QUERY)) begin
          oc_nxt    = in_data.out_channel;
          tm_nxt    = in_data.time_index;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        err_nxt   = err_calc;
        base_nxt  = base_calc;
        idx_nxt   = base_calc;
        ci_nxt    = '0;
        k_nxt     = '0;
        state_nxt = err_calc ? S_OUT : S_RUN;
      end
      S_RUN: begin
        if (k_last) begin
          k_nxt   = '0;
          idx_nxt = base_r;
          if (ci_last) begin
            state_nxt = S_DRAIN;
          end else begin
            ci_nxt = ci_r + 1'b1;
          end
        end else begin
          k_nxt   = k_r + 1'b1;
          idx_nxt = idx_r + $signed({8'd0, d_use});
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !mac_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.result = err_r ? '0 : mac_result;
          out_data_nxt.status = err_r ? ST_RANGE : ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= (state_r == S_RUN);
    end
  end

  always_ff @(posedge clk) begin
    oc_r       <= oc_nxt;
    tm_r       <= tm_nxt;
    ci_r       <= ci_nxt;
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    err_r      <= err_nxt;
    rd_use_r   <= idx_ok;
    out_data_r <= out_data_nxt;
  end

  assign mac_ctl.clear    = (state_r == S_CHECK);
  assign mac_ctl.valid    = rd_v_r;
  assign mac_ctl.use_prod = rd_use_r;

  dsc_store #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .MAX_TAPS         (MAX_TAPS),
    .MAX_LENGTH       (MAX_LENGTH)
  ) u_store (
    .clk        (clk),
    .ld_en      (in_acc),
    .ld_beat    (in_data),
    .bias_rd_en (in_acc && (in_data.op == OP_QUERY)),
    .bias_rd_oc (in_data.out_channel),
    .rd_en      (state_r == S_RUN),
    .rd_oc      (oc_r),
    .rd_ci      (ci_r),
    .rd_k       (k_r),
    .rd_t       (idx_r[SI_W-1:0]),
    .bias_q     (bias_q),
    .weight_q   (weight_q),
    .sample_q   (sample_q)
  );

  dsc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .bias   (bias_q),
    .w      (weight_q),
    .x      (sample_q),
    .busy   (mac_busy),
    .result (mac_result)
  );

endmodule

@@ sv/dsc_store.sv @@
// ----------------------------------------------------------------------------
// dsc_store
// Weight, bias and sample memories: load decode on the write side, one
// registered read per memory for the sequencer.
// ----------------------------------------------------------------------------
module dsc_store import dsc_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
  parameter int MAX_TAPS         = DEF_MAX_TAPS,
  parameter int MAX_LENGTH       = DEF_MAX_LENGTH,
  localparam int CI_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1,
  localparam int K_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int SI_W = $clog2(MAX_LENGTH)
) (
  input  logic                     clk,
  // load side
  input  logic                     ld_en,
  input  dsc_in_t                  ld_beat,
  // read side
  input  logic                     bias_rd_en,
  input  logic [3:0]               bias_rd_oc,
  input  logic                     rd_en,
  input  logic [3:0]               rd_oc,
  input  logic [CI_W-1:0]          rd_ci,
  input  logic [K_W-1:0]           rd_k,
  input  logic [SI_W-1:0]          rd_t,
  output logic signed [DATA_W-1:0] bias_q,
  output logic signed [DATA_W-1:0] weight_q,
  output logic signed [DATA_W-1:0] sample_q
);

  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
  localparam int S_DEPTH = MAX_IN_CHANNELS * MAX_LENGTH;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int SA_W    = $clog2(S_DEPTH);
  localparam int BA_W    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

  logic signed [DATA_W-1:0] weight_mem [W_DEPTH];
  logic signed [DATA_W-1:0] sample_mem [S_DEPTH];
  logic signed [DATA_W-1:0] bias_mem   [MAX_OUT_CHANNELS];

  logic            w_we, s_we, b_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [SA_W-1:0] s_waddr, s_raddr;
  logic [BA_W-1:0] b_waddr, b_raddr;

  always_comb begin
    w_we = ld_en && (ld_beat.op == OP_LOAD_WEIGHT) &&
           (32'(ld_beat.out_channel) < MAX_OUT_CHANNELS) &&
           (32'(ld_beat.in_channel) < MAX_IN_CHANNELS) &&
           (32'(ld_beat.tap) < MAX_TAPS);
    b_we = ld_en && (ld_beat.op == OP_LOAD_BIAS) &&
           (32'(ld_beat.out_channel) < MAX_OUT_CHANNELS);
    s_we = ld_en && (ld_beat.op == OP_LOAD_SAMPLE) &&
           (32'(ld_beat.in_channel) < MAX_IN_CHANNELS) &&
           (32'(ld_beat.time_index) < MAX_LENGTH);

    w_waddr = WA_W'((32'(ld_beat.out_channel) * MAX_IN_CHANNELS +
                     32'(ld_beat.in_channel)) * MAX_TAPS + 32'(ld_beat.tap));
    s_waddr = SA_W'(32'(ld_beat.in_channel) * MAX_LENGTH + 32'(ld_beat.time_index));
    b_waddr = BA_W'(ld_beat.out_channel);

    w_raddr = WA_W'((32'(rd_oc) * MAX_IN_CHANNELS + 32'(rd_ci)) * MAX_TAPS + 32'(rd_k));
    s_raddr = SA_W'(32'(rd_ci) * MAX_LENGTH + 32'(rd_t));
    b_raddr = BA_W'(bias_rd_oc);
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= ld_beat.value;
    end
    if (rd_en) begin
      weight_q <= weight_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sample_mem[s_waddr] <= ld_beat.value;
    end
    if (rd_en) begin
      sample_q <= sample_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[b_waddr] <= ld_beat.value;
    end
    if (bias_rd_en) begin
      bias_q <= bias_mem[b_raddr];
    end
  end

endmodule

@@ sv/dsc_mac.sv @@
// ----------------------------------------------------------------------------
// dsc_mac
// Shared multiply-accumulate: registered product, wide accumulator, and
// round-half-up to Q.12 with 32-bit saturation on the output.
// ----------------------------------------------------------------------------
module dsc_mac import dsc_pkg::*; #(
  parameter int ACC_W = 44
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dsc_mac_ctl_t               ctl,
  input  logic signed [DATA_W-1:0]   bias,
  input  logic signed [DATA_W-1:0]   w,
  input  logic signed [DATA_W-1:0]   x,
  output logic                       busy,
  output logic signed [RESULT_W-1:0] result
);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-RESULT_W){1'b0}}, 1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-RESULT_W){1'b1}}, 1'b1, {(RESULT_W-1){1'b0}}};

  logic signed [2*DATA_W-1:0] prod_r;
  logic                       prod_v_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    shr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.valid;
    end
  end

  // Out-of-window taps contribute zero
  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.use_prod) begin
      prod_r <= w * x;
    end else begin
      prod_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= $signed(ACC_W'(bias)) <<< FRAC_BITS;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Arithmetic shift gives floor, which with the half offset is round half up
  always_comb begin
    rnd = acc_r + $signed(ACC_W'(ROUND_HALF));
    shr = rnd >>> FRAC_BITS;
    priority if (shr > SAT_MAX) begin
      result = SAT_MAX[RESULT_W-1:0];
    end else if (shr < SAT_MIN) begin
      result = SAT_MIN[RESULT_W-1:0];
    end else begin
      result = shr[RESULT_W-1:0];
    end
  end

  assign busy = prod_v_r;

endmodule

@@ sv/dsc_checker.sv @@
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module dsc_checker import dsc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input dsc_in_t               in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input dsc_out_t              out_data
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a query occupies the block past its accepting edge
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_data.op == OP_QUERY) |=> in_stall)
    else $error("input not stalled after query");

  // loads never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_data.op != OP_QUERY) && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RANGE) |-> (out_data.result == '0))
    else $error("error result carries nonzero value");

endmodule

bind dilated_strided_conv1d dsc_checker u_dsc_checker (.*);

@@ tb/dsc_conv_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsc_conv_checker
// Watches the load/query, result and register channels of the conv1d block,
// keeps its own copy of the stores and shape registers, works out each
// query's result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module dsc_conv_checker import dsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  dsc_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  dsc_out_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           errors,
  output int unsigned           pending
);

  logic signed [DATA_W-1:0] weight_mem [DEF_MAX_OUT_CHANNELS*DEF_MAX_IN_CHANNELS*DEF_MAX_TAPS];
  logic signed [DATA_W-1:0] bias_mem   [DEF_MAX_OUT_CHANNELS];
  logic signed [DATA_W-1:0] sample_mem [DEF_MAX_IN_CHANNELS*DEF_MAX_LENGTH];

  logic [3:0] stride_q;
  logic [7:0] pad_q;
  logic [4:0] dil_q;
  logic [4:0] taps_q;
  logic [4:0] cin_q;
  logic [4:0] cout_q;
  logic [8:0] len_q;

  dsc_out_t    owed_results [$];
  int unsigned fail_cnt = 0;

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic dsc_out_t conv_point(dsc_in_t q);
    int       s, p, d, kn, cin, cout, len, num, pos, oc, tm;
    longint   acc;
    longint   r;
    dsc_out_t res;
    s    = clamp(stride_q, 1, 8);
    p    = pad_q;
    d    = clamp(dil_q, 1, 16);
    kn   = clamp(taps_q, 1, DEF_MAX_TAPS);
    cin  = clamp(cin_q, 1, DEF_MAX_IN_CHANNELS);
    cout = clamp(cout_q, 1, DEF_MAX_OUT_CHANNELS);
    len  = clamp(len_q, 1, DEF_MAX_LENGTH);
    oc   = q.out_channel;
    tm   = q.time_index;
    num  = len + 2 * p - d * (kn - 1) - 1;
    res.result = '0;
    res.status = ST_RANGE;
    if (num < 0 || tm > num / s || oc >= cout) return res;
    acc = longint'(bias_mem[oc]) * (64'sd1 << FRAC_BITS);
    for (int ci = 0; ci < cin; ci++) begin
      for (int k = 0; k < kn; k++) begin
        pos = tm * s - p + k * d;
        // taps landing in the padding contribute nothing
        if (pos >= 0 && pos < len)
          acc += longint'(weight_mem[(oc * DEF_MAX_IN_CHANNELS + ci) * DEF_MAX_TAPS + k]) *
                 longint'(sample_mem[ci * DEF_MAX_LENGTH + pos]);
      end
    end
    // floor shift after adding half gives round half up
    r = (acc + ROUND_HALF) >>> FRAC_BITS;
    if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
    res.result = r[RESULT_W-1:0];
    res.status = ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    dsc_out_t want;
    if (!rst_n) begin
      stride_q = 4'd1;
      pad_q    = 8'd0;
      dil_q    = 5'd1;
      taps_q   = 5'd1;
      cin_q    = 5'd1;
      cout_q   = 5'd1;
      len_q    = 9'd256;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRIDE:       stride_q = cfg_data[3:0];
          REG_PADDING:      pad_q    = cfg_data[7:0];
          REG_DILATION:     dil_q    = cfg_data[4:0];
          REG_KERNEL_SIZE:  taps_q   = cfg_data[4:0];
          REG_IN_CHANNELS:  cin_q    = cfg_data[4:0];
          REG_OUT_CHANNELS: cout_q   = cfg_data[4:0];
          REG_IN_LENGTH:    len_q    = cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no query outstanding");
          fail_cnt++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            fail_cnt++;
          end
          if (out_data.result !== want.result) begin
            $error("result: expected %0d, actual %0d", want.result, out_data.result);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.op)
          OP_LOAD_WEIGHT:
            weight_mem[(in_data.out_channel * DEF_MAX_IN_CHANNELS + in_data.in_channel) *
                       DEF_MAX_TAPS + in_data.tap] = in_data.value;
          OP_LOAD_BIAS:
            bias_mem[in_data.out_channel] = in_data.value;
          OP_LOAD_SAMPLE:
            sample_mem[in_data.in_channel * DEF_MAX_LENGTH + in_data.time_index] = in_data.value;
          OP_QUERY:
            owed_results.push_back(conv_point(in_data));
          default: ;
        endcase
      end
    end
    errors  <= fail_cnt;
    pending <= owed_results.size();
  end

endmodule

@@ tb/dilated_strided_conv1d_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dilated_strided_conv1d_tb
// Drives loads and queries into the conv1d block under a series of shape
// settings (reset values, out-of-range and extreme registers, random ones),
// filling every store entry a query will read before the query goes out.
// Both sides idle at random; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module dilated_strided_conv1d_tb;
  import dsc_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int MAX_GAP       = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 3000;
  // unmapped register index, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  dsc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dsc_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int          sent        = 0;
  bit          no_idle     = 1'b0;

  // shape in effect, after range limiting
  int stride_e = 1;
  int pad_e    = 0;
  int dil_e    = 1;
  int taps_e   = 1;
  int cin_e    = 1;
  int cout_e   = 1;
  int len_e    = 256;
  int out_len  = 256;

  bit weight_set [DEF_MAX_OUT_CHANNELS*DEF_MAX_IN_CHANNELS*DEF_MAX_TAPS];
  bit bias_set   [DEF_MAX_OUT_CHANNELS];
  bit sample_set [DEF_MAX_IN_CHANNELS*DEF_MAX_LENGTH];

  dilated_strided_conv1d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dsc_conv_checker conv_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int reg_width(logic [CFG_IDX_W-1:0] r);
    case (r)
      REG_STRIDE:    return 4;
      REG_PADDING:   return 8;
      REG_IN_LENGTH: return 9;
      default:       return 5;
    endcase
  endfunction

  function automatic int field(logic [CFG_IDX_W-1:0] r, int unsigned v);
    return v & ((1 << reg_width(r)) - 1);
  endfunction

  // mostly in range, sometimes anything the field holds, sometimes junk above it
  function automatic int unsigned raw_value(logic [CFG_IDX_W-1:0] r, int lo, int hi);
    int          w;
    int unsigned v;
    w = reg_width(r);
    v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << w) - 1) : $urandom_range(lo, hi);
    if (w < CFG_DATA_W && $urandom_range(0, 9) == 0)
      v |= $urandom_range(1, (1 << (CFG_DATA_W - w)) - 1) << w;
    return v;
  endfunction

  task automatic send(dsc_in_t beat);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic load(logic [1:0] op, int oc, int ic, int tap, int tm, logic [15:0] val);
    dsc_in_t beat;
    beat.op          = op;
    beat.out_channel = oc[3:0];
    beat.in_channel  = ic[3:0];
    beat.tap         = tap[3:0];
    beat.time_index  = tm[7:0];
    beat.value       = val;
    case (op)
      OP_LOAD_WEIGHT: weight_set[(oc * DEF_MAX_IN_CHANNELS + ic) * DEF_MAX_TAPS + tap] = 1'b1;
      OP_LOAD_BIAS:   bias_set[oc] = 1'b1;
      OP_LOAD_SAMPLE: sample_set[ic * DEF_MAX_LENGTH + tm] = 1'b1;
      default: ;
    endcase
    send(beat);
  endtask

  // a valid query first gets every weight, bias and sample it reads loaded
  task automatic query_at(int oc, int tm);
    int      pos;
    dsc_in_t beat;
    if (oc < cout_e && tm < out_len) begin
      if (!bias_set[oc])
        load(OP_LOAD_BIAS, oc, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom_range(0, 255), 16'($urandom));
      for (int ci = 0; ci < cin_e; ci++) begin
        for (int k = 0; k < taps_e; k++) begin
          pos = tm * stride_e - pad_e + k * dil_e;
          if (!weight_set[(oc * DEF_MAX_IN_CHANNELS + ci) * DEF_MAX_TAPS + k])
            load(OP_LOAD_WEIGHT, oc, ci, k, $urandom_range(0, 255), 16'($urandom));
          if (pos >= 0 && pos < len_e && !sample_set[ci * DEF_MAX_LENGTH + pos])
            load(OP_LOAD_SAMPLE, $urandom_range(0, 15), ci, $urandom_range(0, 15), pos,
                 16'($urandom));
        end
      end
    end
    beat.op          = OP_QUERY;
    beat.out_channel = oc[3:0];
    beat.in_channel  = 4'($urandom);
    beat.tap         = 4'($urandom);
    beat.time_index  = tm[7:0];
    beat.value       = 16'($urandom);
    send(beat);
  endtask

  task automatic random_load();
    int   pick;
    bit   in_use;
    logic [1:0] op;
    pick   = $urandom_range(0, 2);
    in_use = $urandom_range(0, 1);
    op = (pick == 0) ? OP_LOAD_WEIGHT : (pick == 1) ? OP_LOAD_BIAS : OP_LOAD_SAMPLE;
    load(op,
         in_use ? $urandom_range(0, cout_e - 1) : $urandom_range(0, 15),
         in_use ? $urandom_range(0, cin_e - 1) : $urandom_range(0, 15),
         in_use ? $urandom_range(0, taps_e - 1) : $urandom_range(0, 15),
         in_use ? $urandom_range(0, len_e - 1) : $urandom_range(0, 255),
         16'($urandom));
  endtask

  task automatic run_items(int count);
    int stop_at;
    int pick;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && out_len > 0)
        query_at($urandom_range(0, cout_e - 1), $urandom_range(0, clamp(out_len, 1, 256) - 1));
      else if (pick < 68)
        query_at($urandom_range(0, 15), $urandom_range(0, 255));
      else
        random_load();
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] r, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int unsigned st, int unsigned pd, int unsigned dl, int unsigned ks,
                           int unsigned ci, int unsigned co, int unsigned ln);
    int num;
    settle();
    write_reg(REG_STRIDE, st);
    write_reg(REG_PADDING, pd);
    write_reg(REG_DILATION, dl);
    write_reg(REG_KERNEL_SIZE, ks);
    write_reg(REG_IN_CHANNELS, ci);
    write_reg(REG_OUT_CHANNELS, co);
    write_reg(REG_IN_LENGTH, ln);
    write_reg(REG_SPARE, $urandom_range(0, (1 << CFG_DATA_W) - 1));
    cfg_valid <= 1'b0;
    stride_e = clamp(field(REG_STRIDE, st), 1, 8);
    pad_e    = field(REG_PADDING, pd);
    dil_e    = clamp(field(REG_DILATION, dl), 1, 16);
    taps_e   = clamp(field(REG_KERNEL_SIZE, ks), 1, DEF_MAX_TAPS);
    cin_e    = clamp(field(REG_IN_CHANNELS, ci), 1, DEF_MAX_IN_CHANNELS);
    cout_e   = clamp(field(REG_OUT_CHANNELS, co), 1, DEF_MAX_OUT_CHANNELS);
    len_e    = clamp(field(REG_IN_LENGTH, ln), 1, DEF_MAX_LENGTH);
    num      = len_e + 2 * pad_e - dil_e * (taps_e - 1) - 1;
    out_len  = (num < 0) ? 0 : num / stride_e + 1;
    no_idle  = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: one channel, one tap, full length
    load(OP_LOAD_WEIGHT, 0, 0, 0, 0, 16'h7FFF);
    load(OP_LOAD_BIAS, 0, 0, 0, 0, 16'h8000);
    load(OP_LOAD_SAMPLE, 0, 0, 0, 0, 16'h7FFF);
    load(OP_LOAD_SAMPLE, 0, 0, 0, 255, 16'h8000);
    query_at(0, 0);
    query_at(0, 255);
    query_at(1, 0);
    query_at(15, 255);
    load(OP_LOAD_WEIGHT, 15, 15, 15, 255, 16'h0001);
    load(OP_LOAD_BIAS, 15, 15, 15, 255, 16'hFFFF);
    load(OP_LOAD_SAMPLE, 15, 15, 15, 128, 16'h5555);
    // one-LSB weight, zero bias: exercise rounding at the half-LSB boundaries
    load(OP_LOAD_WEIGHT, 0, 0, 0, 0, 16'h0001);
    load(OP_LOAD_BIAS, 0, 0, 0, 0, 16'h0000);
    load(OP_LOAD_SAMPLE, 0, 0, 0, 1, 16'h0800);
    query_at(0, 1);
    load(OP_LOAD_SAMPLE, 0, 0, 0, 2, 16'hF800);
    query_at(0, 2);
    load(OP_LOAD_SAMPLE, 0, 0, 0, 3, 16'hF7FF);
    query_at(0, 3);

    // kernel span longer than the padded input: no valid output position
    configure(1, 0, 16, 16, 1, 1, 4);
    run_items(20);
    // zero in every register but padding reads as the minimum
    configure(0, 3, 0, 0, 0, 0, 0);
    run_items(60);
    // all-ones fields, limited to the top of each range
    configure(15, 255, 31, 31, 31, 31, 511);
    run_items(100);
    configure(1, 0, 1, 2, 1, 2, 256);
    run_items(150);

    while (sent < ITEM_TARGET) begin
      configure(raw_value(REG_STRIDE, 1, 8),
                raw_value(REG_PADDING, 0, ($urandom_range(0, 3) == 0) ? 255 : 4),
                raw_value(REG_DILATION, 1, ($urandom_range(0, 3) == 0) ? 16 : 3),
                raw_value(REG_KERNEL_SIZE, 1, ($urandom_range(0, 7) == 0) ? 16 : 4),
                raw_value(REG_IN_CHANNELS, 1, ($urandom_range(0, 7) == 0) ? 16 : 3),
                raw_value(REG_OUT_CHANNELS, 1, ($urandom_range(0, 7) == 0) ? 16 : 4),
                raw_value(REG_IN_LENGTH, 1, ($urandom_range(0, 7) == 0) ? 256 : 32));
      run_items($urandom_range(40, 120));
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/dsc_pkg.sv
sv/dsc_store.sv
sv/dsc_mac.sv
sv/dilated_strided_conv1d.sv
sv/dsc_checker.sv
tb/dsc_conv_checker.sv
tb/dilated_strided_conv1d_tb.sv
